[hw/rtl/fbdr_pkg.sv]
// Shared types and constants for the framebuffer dirty-rectangle flush block.
package fbdr_pkg;

	typedef enum logic [1:0] {
		MODE_PIXEL = 2'd0,
		MODE_FILL  = 2'd1,
		MODE_FLUSH = 2'd2,
		MODE_NEXT  = 2'd3
	} mode_t;

	localparam logic [1:0] KIND_ACK    = 2'd0;
	localparam logic [1:0] KIND_WINDOW = 2'd1;
	localparam logic [1:0] KIND_PIXEL  = 2'd2;

	localparam logic REG_COLUMNS = 1'b0;
	localparam logic REG_ROWS    = 1'b1;

	localparam logic [7:0] COLUMNS_RESET = 8'd128;
	localparam logic [7:0] ROWS_RESET    = 8'd160;
	localparam logic [7:0] NO_REGION     = 8'hff;

	// controller -> datapath
	typedef struct packed {
		logic take;       // item accepted this cycle
		logic clr_step;   // write zero at the clear counter, advance it
		logic fill_step;  // write fill colour at the fill cursor, advance it
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic clr_last;   // clear counter sits on the final entry
		logic fill_go;    // offered item is a fill with a non-empty clipped area
		logic fill_last;  // fill cursor sits on the final pixel
	} sts_t;

endpackage

[hw/rtl/fbdr_ctrl.sv]
// Controller: clearing pass, idle/accept, rectangle fill sequencing and output valid.
module fbdr_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	output logic          m_tvalid,
	input  logic          m_tready,
	input  fbdr_pkg::sts_t sts,
	output fbdr_pkg::cmd_t cmd
);
	import fbdr_pkg::*;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FILL
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   take;

	assign s_tready = (state_q == ST_IDLE) && (!out_valid_q || m_tready);
	assign take     = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;

	always_comb begin
		cmd.take      = take;
		cmd.clr_step  = (state_q == ST_CLEAR);
		cmd.fill_step = (state_q == ST_FILL);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			// every accepted item answers at once; a fill then writes its area
			if (take) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					if (sts.clr_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (take && sts.fill_go) begin
						state_q <= ST_FILL;
					end
				end
				ST_FILL: begin
					if (sts.fill_last) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

endmodule

[hw/rtl/fbdr_dp.sv]
// Datapath: pixel store, dirty rectangle, flush cursor, fill cursor and result registers.
module fbdr_dp #(
	parameter int WIDTH  = 128,
	parameter int HEIGHT = 160
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_wen,
	input  logic           cfg_index,
	input  logic [7:0]     cfg_wdata,
	input  logic [1:0]     mode,
	input  logic [7:0]     x_first,
	input  logic [7:0]     y_first,
	input  logic [7:0]     x_limit,
	input  logic [7:0]     y_limit,
	input  logic [15:0]    color,
	input  fbdr_pkg::cmd_t cmd,
	output fbdr_pkg::sts_t sts,
	output logic [1:0]     kind,
	output logic [7:0]     win_left,
	output logic [7:0]     win_top,
	output logic [7:0]     win_right,
	output logic [7:0]     win_bottom,
	output logic [15:0]    pixel,
	output logic           empty_res,
	output logic           last
);
	import fbdr_pkg::*;

	localparam int DEPTH = WIDTH * HEIGHT;
	localparam int AW    = $clog2(DEPTH);

	logic [15:0]   mem [DEPTH];
	logic [15:0]   rdata_q;

	logic [7:0]    columns_q, rows_q;
	logic [7:0]    cols, rows;
	logic [7:0]    dl_q, dt_q, dr_q, db_q;
	logic [7:0]    cur_col_q, cur_row_q;
	logic          flushing_q;
	logic [AW-1:0] clr_q;
	logic [7:0]    fcol_q, frow_q, fx0_q, fx1_q, fy1_q;
	logic [15:0]   fcolor_q;

	logic [1:0]    kind_q;
	logic [7:0]    wl_q, wt_q, wr_q, wb_q;
	logic          empty_q, last_q, pix_sel_q;

	mode_t         mode_in;
	logic          pix_ok, fill_ok, region_empty;
	logic [7:0]    x1c, y1c;
	logic          grow;
	logic [7:0]    gl, gt, gr, gb;
	logic          col_more, row_more;
	logic          fcol_more, frow_more;

	logic [7:0]    row_sel, col_sel;
	logic [AW-1:0] addr;
	logic          mem_we, mem_re;
	logic [15:0]   mem_wdata;

	assign mode_in = mode_t'(mode);
	assign cols    = (columns_q < 8'(WIDTH)) ? columns_q : 8'(WIDTH);
	assign rows    = (rows_q < 8'(HEIGHT)) ? rows_q : 8'(HEIGHT);

	assign pix_ok  = (x_first < cols) && (y_first < rows);
	assign x1c     = (x_limit > cols) ? cols : x_limit;
	assign y1c     = (y_limit > rows) ? rows : y_limit;
	assign fill_ok = (x1c > x_first) && (y1c > y_first);

	assign region_empty = (dl_q >= dr_q) || (dt_q >= db_q);

	assign col_more  = ({1'b0, cur_col_q} + 9'd1) < {1'b0, dr_q};
	assign row_more  = ({1'b0, cur_row_q} + 9'd1) < {1'b0, db_q};
	assign fcol_more = ({1'b0, fcol_q} + 9'd1) < {1'b0, fx1_q};
	assign frow_more = ({1'b0, frow_q} + 9'd1) < {1'b0, fy1_q};

	always_comb begin
		sts.clr_last  = (clr_q == AW'(DEPTH - 1));
		sts.fill_go   = (mode_in == MODE_FILL) && fill_ok;
		sts.fill_last = !fcol_more && !frow_more;
	end

	// rectangle to merge into the dirty window for this beat
	always_comb begin
		grow = 1'b0;
		gl   = x_first;
		gt   = y_first;
		gr   = x1c;
		gb   = y1c;
		case (mode_in)
			MODE_PIXEL: begin
				grow = cmd.take && pix_ok;
				gr   = x_first + 8'd1;
				gb   = y_first + 8'd1;
			end
			MODE_FILL: begin
				grow = cmd.take && fill_ok;
			end
			default: begin
				grow = 1'b0;
			end
		endcase
	end

	// one address generator for every store access
	always_comb begin
		row_sel   = cur_row_q;
		col_sel   = cur_col_q;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_wdata = color;
		if (cmd.fill_step) begin
			row_sel   = frow_q;
			col_sel   = fcol_q;
			mem_we    = 1'b1;
			mem_wdata = fcolor_q;
		end else if (cmd.take && (mode_in == MODE_PIXEL)) begin
			row_sel = y_first;
			col_sel = x_first;
			mem_we  = pix_ok;
		end else if (cmd.take && (mode_in == MODE_NEXT)) begin
			mem_re = flushing_q;
		end
		if (cmd.clr_step) begin
			mem_we    = 1'b1;
			mem_wdata = 16'd0;
		end
	end

	assign addr = cmd.clr_step ? clr_q
	            : (AW'(row_sel) * AW'(WIDTH) + AW'(col_sel));

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[addr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[addr];
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			columns_q <= COLUMNS_RESET;
			rows_q    <= ROWS_RESET;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_COLUMNS: columns_q <= cfg_wdata;
				REG_ROWS:    rows_q    <= cfg_wdata;
				default:     columns_q <= columns_q;
			endcase
		end
	end

	// dirty window, flush cursor, clear counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dl_q       <= NO_REGION;
			dt_q       <= NO_REGION;
			dr_q       <= 8'd0;
			db_q       <= 8'd0;
			cur_col_q  <= 8'd0;
			cur_row_q  <= 8'd0;
			flushing_q <= 1'b0;
			clr_q      <= '0;
		end else begin
			if (cmd.clr_step) begin
				clr_q <= clr_q + AW'(1);
			end
			if (grow) begin
				if (gl < dl_q) dl_q <= gl;
				if (gt < dt_q) dt_q <= gt;
				if (gr > dr_q) dr_q <= gr;
				if (gb > db_q) db_q <= gb;
			end
			if (cmd.take && (mode_in == MODE_FLUSH)) begin
				if (region_empty) begin
					flushing_q <= 1'b0;
					cur_col_q  <= 8'd0;
					cur_row_q  <= 8'd0;
				end else begin
					flushing_q <= 1'b1;
					cur_col_q  <= dl_q;
					cur_row_q  <= dt_q;
				end
			end
			if (cmd.take && (mode_in == MODE_NEXT) && flushing_q) begin
				if (col_more) begin
					cur_col_q <= cur_col_q + 8'd1;
				end else if (row_more) begin
					cur_col_q <= dl_q;
					cur_row_q <= cur_row_q + 8'd1;
				end else begin
					dl_q       <= NO_REGION;
					dt_q       <= NO_REGION;
					dr_q       <= 8'd0;
					db_q       <= 8'd0;
					cur_col_q  <= 8'd0;
					cur_row_q  <= 8'd0;
					flushing_q <= 1'b0;
				end
			end
		end
	end

	// fill cursor and latched fill bounds
	always_ff @(posedge clk) begin
		if (cmd.take && sts.fill_go) begin
			fcol_q   <= x_first;
			frow_q   <= y_first;
			fx0_q    <= x_first;
			fx1_q    <= x1c;
			fy1_q    <= y1c;
			fcolor_q <= color;
		end else if (cmd.fill_step) begin
			if (fcol_more) begin
				fcol_q <= fcol_q + 8'd1;
			end else begin
				fcol_q <= fx0_q;
				frow_q <= frow_q + 8'd1;
			end
		end
	end

	// result register, loaded on the accepting beat
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			kind_q    <= KIND_ACK;
			wl_q      <= 8'd0;
			wt_q      <= 8'd0;
			wr_q      <= 8'd0;
			wb_q      <= 8'd0;
			empty_q   <= 1'b0;
			last_q    <= 1'b0;
			pix_sel_q <= 1'b0;
			case (mode_in)
				MODE_FLUSH: begin
					kind_q  <= KIND_WINDOW;
					wl_q    <= dl_q;
					wt_q    <= dt_q;
					wr_q    <= dr_q;
					wb_q    <= db_q;
					empty_q <= region_empty;
				end
				MODE_NEXT: begin
					if (flushing_q) begin
						kind_q    <= KIND_PIXEL;
						wl_q      <= dl_q;
						wt_q      <= dt_q;
						wr_q      <= dr_q;
						wb_q      <= db_q;
						last_q    <= !col_more && !row_more;
						pix_sel_q <= 1'b1;
					end
				end
				default: begin
					kind_q <= KIND_ACK;
				end
			endcase
		end
	end

	assign kind       = kind_q;
	assign win_left   = wl_q;
	assign win_top    = wt_q;
	assign win_right  = wr_q;
	assign win_bottom = wb_q;
	assign pixel      = pix_sel_q ? rdata_q : 16'd0;
	assign empty_res  = empty_q;
	assign last       = last_q;

endmodule

[hw/rtl/framebuffer_dirty_rect_flush.sv]
// Top level of the framebuffer with dirty-rectangle tracking and flush readout.
//
// Commands arrive as beats on the s_ side: s_tuser carries the mode (set pixel,
// fill rectangle, start flush, next flush pixel), s_tdata the coordinates and colour.
// Every command beat yields exactly one result beat on the m_ side: m_tuser
// carries the result kind, m_tlast marks the final pixel of a flush.
// Results appear in the cycle after the command is accepted and sit in an output
// register; a new command is taken in the same cycle the waiting result is taken.
// Pixel writes, flush starts and flushed pixels sustain one beat per cycle while the
// receiver keeps up; the flushed pixel comes from the registered read port of the
// single-port store. A fill answers at once, then occupies the store port, writing
// each pixel of its clipped area, before the next command is taken.
// After reset the store is swept to zero, one entry per cycle, over all WIDTH*HEIGHT
// entries (20480 at the default size); s_tready stays low during that sweep.
// Configuration writes (column and row count) are taken at any time, including
// during the sweep. When the receiver stalls, the result holds and s_tready drops.
module framebuffer_dirty_rect_flush #(
	parameter int WIDTH  = 128,
	parameter int HEIGHT = 160
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_wen,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_wdata,
	// command stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // x_first, y_first, x_limit, y_limit, color
	input  logic [1:0]  s_tuser,   // mode
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // win_left, win_top, win_right, win_bottom, pixel,
	                               // empty_res, zero fill
	output logic [1:0]  m_tuser,   // kind
	output logic        m_tlast    // last
);
	import fbdr_pkg::*;

	cmd_t        cmd;
	sts_t        sts;
	logic [7:0]  win_left, win_top, win_right, win_bottom;
	logic [15:0] pixel;
	logic        empty_res;

	// sequencing: clearing sweep, accept, fill walk, result valid
	fbdr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// store, dirty window and result payload
	fbdr_dp #(
		.WIDTH  (WIDTH),
		.HEIGHT (HEIGHT)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wen    (cfg_wen),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.mode       (s_tuser),
		.x_first    (s_tdata[7:0]),
		.y_first    (s_tdata[15:8]),
		.x_limit    (s_tdata[23:16]),
		.y_limit    (s_tdata[31:24]),
		.color      (s_tdata[47:32]),
		.cmd        (cmd),
		.sts        (sts),
		.kind       (m_tuser),
		.win_left   (win_left),
		.win_top    (win_top),
		.win_right  (win_right),
		.win_bottom (win_bottom),
		.pixel      (pixel),
		.empty_res  (empty_res),
		.last       (m_tlast)
	);

	// pack the result beat, lowest field first
	assign m_tdata = {7'd0, empty_res, pixel, win_bottom, win_right, win_top, win_left};

endmodule
